// ===== rtl/ps2m_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse engine package
// Shared types, codes and sequencing helpers for the mouse device engine.
// ----------------------------------------------------------------------------
package ps2m_pkg;

  localparam int FIFO_DEPTH_DEF     = 256;
  localparam int EVENT_HEADROOM_DEF = 16;
  localparam int ACCUM_WIDTH_DEF    = 16;

  localparam logic [7:0] REPLY_ACK  = 8'hFA;
  localparam logic [7:0] REPLY_BAT  = 8'hAA;

  localparam logic [7:0] CMD_SCALE11  = 8'hE6;
  localparam logic [7:0] CMD_SCALE21  = 8'hE7;
  localparam logic [7:0] CMD_SET_RES  = 8'hE8;
  localparam logic [7:0] CMD_INFO     = 8'hE9;
  localparam logic [7:0] CMD_STREAM   = 8'hEA;
  localparam logic [7:0] CMD_POLL     = 8'hEB;
  localparam logic [7:0] CMD_WRAP_OFF = 8'hEC;
  localparam logic [7:0] CMD_WRAP_ON  = 8'hEE;
  localparam logic [7:0] CMD_REMOTE   = 8'hF0;
  localparam logic [7:0] CMD_GET_ID   = 8'hF2;
  localparam logic [7:0] CMD_SET_RATE = 8'hF3;
  localparam logic [7:0] CMD_ENABLE   = 8'hF4;
  localparam logic [7:0] CMD_DISABLE  = 8'hF5;
  localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
  localparam logic [7:0] CMD_RESET    = 8'hFF;

  localparam int ST_SCALE21_BIT = 4;
  localparam int ST_ENABLED_BIT = 5;
  localparam int ST_REMOTE_BIT  = 6;

  localparam logic [7:0] RATE_200 = 8'd200;
  localparam logic [7:0] RATE_100 = 8'd100;
  localparam logic [7:0] RATE_80  = 8'd80;
  localparam logic [7:0] DEF_RATE = 8'd100;
  localparam logic [7:0] DEF_RES  = 8'd2;

  localparam logic [2:0] KIND_STD  = 3'd0;
  localparam logic [2:0] KIND_IMPS = 3'd3;
  localparam logic [2:0] KIND_IMEX = 3'd4;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_MOTION = 2'd1,
    OP_READ   = 2'd2,
    OP_RESET  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ARG_NONE = 2'd0,
    ARG_RES  = 2'd1,
    ARG_RATE = 2'd2
  } arg_t;

  typedef enum logic [1:0] {
    DET_IDLE = 2'd0,
    DET_200  = 2'd1,
    DET_IMPS = 2'd2,
    DET_IMEX = 2'd3
  } det_t;

  typedef enum logic [2:0] {
    PL_NONE,
    PL_ACK,
    PL_ECHO,
    PL_ACK_KIND,
    PL_INFO,
    PL_POLL,
    PL_RESET
  } plan_t;

  typedef enum logic [3:0] {
    BS_ACK,
    BS_ECHO,
    BS_KIND,
    BS_STATUS,
    BS_RES,
    BS_RATE,
    BS_BAT,
    BS_HEAD,
    BS_DX,
    BS_DY,
    BS_WHEEL
  } bsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CMD,
    S_PUSH,
    S_MOT_ACC,
    S_MOT_CHK,
    S_PKT,
    S_PKT_SUB,
    S_PKT_CHK,
    S_RD,
    S_RD_WAIT,
    S_RST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  exec;
    logic  push;
    bsel_t bsel;
    logic  rd;
    logic  capture;
    logic  acc;
    logic  held_set;
    logic  pkt_sub;
    logic  acc_clear;
    logic  dev_reset;
    logic  clear_wr;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  enabled;
    logic  remote;
    logic  room;
    logic  full;
    logic  accum_zero;
    logic  null_event;
    logic  kind_ext;
    logic  clear_last;
  } dp_status_t;

  function automatic bsel_t plan_byte(plan_t plan, logic [1:0] k);
    bsel_t b;
    b = BS_ACK;
    unique case (plan)
      PL_ECHO:     b = BS_ECHO;
      PL_ACK_KIND: b = (k == 2'd0) ? BS_ACK : BS_KIND;
      PL_INFO: begin
        case (k)
          2'd0:    b = BS_ACK;
          2'd1:    b = BS_STATUS;
          2'd2:    b = BS_RES;
          default: b = BS_RATE;
        endcase
      end
      PL_RESET: begin
        case (k)
          2'd0:    b = BS_ACK;
          2'd1:    b = BS_BAT;
          default: b = BS_KIND;
        endcase
      end
      default:     b = BS_ACK;
    endcase
    return b;
  endfunction

  function automatic logic plan_last(plan_t plan, logic [1:0] k);
    logic l;
    l = 1'b1;
    unique case (plan)
      PL_ACK_KIND: l = (k == 2'd1);
      PL_INFO:     l = (k == 2'd3);
      PL_RESET:    l = (k == 2'd2);
      default:     l = 1'b1;
    endcase
    return l;
  endfunction

  function automatic bsel_t pkt_byte(logic [1:0] k);
    bsel_t b;
    b = BS_HEAD;
    unique case (k)
      2'd0:    b = BS_HEAD;
      2'd1:    b = BS_DX;
      2'd2:    b = BS_DY;
      default: b = BS_WHEEL;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/ps2m_if.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse engine channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ps2m_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [7:0]        command_byte;
  logic signed [10:0] delta_x;
  logic signed [10:0] delta_y;
  logic signed [10:0] delta_wheel;
  logic [4:0]        button_bits;

  modport source (output valid, operation, command_byte, delta_x, delta_y, delta_wheel,
                  button_bits, input ready);
  modport sink (input valid, operation, command_byte, delta_x, delta_y, delta_wheel,
                button_bits, output ready);
endinterface

interface ps2m_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       irq_level;
  logic [8:0] fifo_level;

  modport source (output valid, read_byte, irq_level, fifo_level, input ready);
  modport sink (input valid, read_byte, irq_level, fifo_level, output ready);
endinterface

// ===== rtl/ps2_mouse_device_engine_top.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse device engine
// Mouse model with IMPS/2 and IMEX extensions, byte FIFO and motion packets.
// ----------------------------------------------------------------------------
// Each item is handled by a controller that moves the FIFO one byte per cycle.
// A data read pops one byte and captures it, a reset clears the device state
// and a host command executes and then pushes its reply bytes; a poll pushes
// its acknowledge and then one movement packet. A motion event is dropped when
// the device is disabled, else accumulated and, in stream mode with room in the
// FIFO, sent as movement packets repeated until the deltas drain. One item is
// in work at a time; the next is taken as soon as the result sits in the output
// register. After rst the FIFO memory is cleared before the first item is taken.
module ps2_mouse_device_engine_top #(
  parameter int FIFO_DEPTH     = ps2m_pkg::FIFO_DEPTH_DEF,
  parameter int EVENT_HEADROOM = ps2m_pkg::EVENT_HEADROOM_DEF,
  parameter int ACCUM_WIDTH    = ps2m_pkg::ACCUM_WIDTH_DEF
) (
  input logic            clk,
  input logic            rst,
  ps2m_item_if.sink      item,
  ps2m_result_if.source  result
);

  ps2m_pkg::dp_cmd_t    cmd;
  ps2m_pkg::dp_status_t status;

  ps2m_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .operation    (item.operation),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .status       (status)
  );

  ps2m_datapath #(
    .FIFO_DEPTH     (FIFO_DEPTH),
    .EVENT_HEADROOM (EVENT_HEADROOM),
    .ACCUM_WIDTH    (ACCUM_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .command_byte (item.command_byte),
    .delta_x      (item.delta_x),
    .delta_y      (item.delta_y),
    .delta_wheel  (item.delta_wheel),
    .button_bits  (item.button_bits),
    .read_byte    (result.read_byte),
    .irq_level    (result.irq_level),
    .fifo_level   (result.fifo_level)
  );

endmodule

// ===== rtl/ps2m_datapath.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse engine datapath
// Byte FIFO, device registers, motion accumulators and packet formatting.
// ----------------------------------------------------------------------------
module ps2m_datapath #(
  parameter int FIFO_DEPTH     = ps2m_pkg::FIFO_DEPTH_DEF,
  parameter int EVENT_HEADROOM = ps2m_pkg::EVENT_HEADROOM_DEF,
  parameter int ACCUM_WIDTH    = ps2m_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ps2m_pkg::dp_cmd_t    cmd,
  output ps2m_pkg::dp_status_t status,
  input  logic [7:0]           command_byte,
  input  logic signed [10:0]   delta_x,
  input  logic signed [10:0]   delta_y,
  input  logic signed [10:0]   delta_wheel,
  input  logic [4:0]           button_bits,
  output logic [7:0]           read_byte,
  output logic                 irq_level,
  output logic [8:0]           fifo_level
);

  localparam int PW    = $clog2(FIFO_DEPTH);
  localparam int CW    = $clog2(FIFO_DEPTH + 1);
  localparam int AW    = ACCUM_WIDTH;
  localparam int EXT_W = (CW > 9) ? CW : 9;
  localparam logic [PW-1:0] PTR_LAST  = PW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(FIFO_DEPTH);
  localparam logic [CW-1:0] CNT_ROOM  = CW'(FIFO_DEPTH - EVENT_HEADROOM);
  localparam logic signed [AW-1:0] LIM127 = AW'(127);
  localparam logic signed [AW-1:0] NEG127 = AW'(-127);
  localparam logic signed [AW-1:0] LIM7   = AW'(7);
  localparam logic signed [AW-1:0] NEG7   = AW'(-7);
  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  logic [7:0]         mem [FIFO_DEPTH];
  logic [7:0]         rdata;
  logic [PW-1:0]      rp;
  logic [PW-1:0]      wp;
  logic [CW-1:0]      count;
  logic [PW-1:0]      clear_addr;
  ps2m_pkg::arg_t     pending;
  logic [7:0]         status_bits;
  logic [7:0]         resolution;
  logic [7:0]         sample_rate;
  logic               wrap_mode;
  logic [2:0]         mouse_kind;
  ps2m_pkg::det_t     detect_phase;
  logic signed [AW-1:0] ax;
  logic signed [AW-1:0] ay;
  logic signed [AW-1:0] aw;
  logic [4:0]         held;
  logic [7:0]         byte_q;
  logic signed [10:0] dx_q;
  logic signed [10:0] dy_q;
  logic signed [10:0] dw_q;
  logic [4:0]         btn_q;
  logic [7:0]         res_byte;
  ps2m_pkg::plan_t    plan_c;

  logic signed [AW-1:0] dx_c;
  logic signed [AW-1:0] dy_c;
  logic signed [AW-1:0] dz127;
  logic signed [AW-1:0] dz7;
  logic signed [AW-1:0] dz_sub;
  logic signed [AW:0]   sum_x;
  logic signed [AW:0]   sum_y;
  logic signed [AW:0]   sum_w;
  logic [7:0]           push_data;
  logic                 mem_we;
  logic [PW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;
  logic [PW-1:0]        raddr;
  logic [EXT_W-1:0]     count_ext;
  logic                 push_ok;

  function automatic logic signed [AW:0] sext(logic signed [10:0] d);
    return (AW+1)'(d);
  endfunction

  function automatic logic signed [AW-1:0] sat(logic signed [AW:0] v);
    logic signed [AW-1:0] r;
    r = v[AW-1:0];
    if (v[AW] != v[AW-1]) begin
      r = v[AW] ? ACC_MIN : ACC_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [AW-1:0] clamp(logic signed [AW-1:0] v,
                                                 logic signed [AW-1:0] hi,
                                                 logic signed [AW-1:0] lo);
    logic signed [AW-1:0] r;
    r = v;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end
    return r;
  endfunction

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  // packet deltas
  assign dx_c   = clamp(ax, LIM127, NEG127);
  assign dy_c   = clamp(ay, LIM127, NEG127);
  assign dz127  = clamp(aw, LIM127, NEG127);
  assign dz7    = clamp(aw, LIM7, NEG7);
  assign dz_sub = (mouse_kind == ps2m_pkg::KIND_IMPS) ? dz127 :
                  (mouse_kind == ps2m_pkg::KIND_IMEX) ? dz7 : aw;

  assign sum_x = sext(dx_q) + {ax[AW-1], ax};
  assign sum_y = {ay[AW-1], ay} - sext(dy_q);
  assign sum_w = sext(dw_q) + {aw[AW-1], aw};

  always_comb begin
    push_data = ps2m_pkg::REPLY_ACK;
    case (cmd.bsel)
      ps2m_pkg::BS_ACK:    push_data = ps2m_pkg::REPLY_ACK;
      ps2m_pkg::BS_ECHO:   push_data = byte_q;
      ps2m_pkg::BS_KIND:   push_data = {5'd0, mouse_kind};
      ps2m_pkg::BS_STATUS: push_data = status_bits;
      ps2m_pkg::BS_RES:    push_data = resolution;
      ps2m_pkg::BS_RATE:   push_data = sample_rate;
      ps2m_pkg::BS_BAT:    push_data = ps2m_pkg::REPLY_BAT;
      ps2m_pkg::BS_HEAD:   push_data = {2'b00, dy_c[AW-1], dx_c[AW-1], 1'b1, held[2:0]};
      ps2m_pkg::BS_DX:     push_data = dx_c[7:0];
      ps2m_pkg::BS_DY:     push_data = dy_c[7:0];
      ps2m_pkg::BS_WHEEL:  push_data = (mouse_kind == ps2m_pkg::KIND_IMEX) ?
                                       {2'b00, held[4:3], dz7[3:0]} : dz127[7:0];
      default:             push_data = ps2m_pkg::REPLY_ACK;
    endcase
  end

  assign push_ok   = cmd.push && (count != CNT_FULL);
  assign mem_we    = push_ok || cmd.clear_wr;
  assign mem_waddr = cmd.clear_wr ? clear_addr : wp;
  assign mem_wdata = cmd.clear_wr ? 8'd0 : push_data;
  // an empty read replays the byte just before the read pointer
  assign raddr     = (count != '0) ? rp : ((rp == '0) ? PTR_LAST : rp - PW'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_wr) begin
      clear_addr <= ptr_inc(clear_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= command_byte;
      dx_q   <= delta_x;
      dy_q   <= delta_y;
      dw_q   <= delta_wheel;
      btn_q  <= button_bits;
    end
    if (cmd.load) begin
      res_byte <= 8'd0;
    end else if (cmd.capture) begin
      res_byte <= rdata;
    end
    if (cmd.out_load) begin
      read_byte  <= res_byte;
      irq_level  <= (count != '0);
      fifo_level <= count_ext[8:0];
    end
  end

  assign count_ext = EXT_W'(count);

  always_ff @(posedge clk) begin
    if (rst || cmd.dev_reset) begin
      rp           <= '0;
      wp           <= '0;
      count        <= '0;
      pending      <= ps2m_pkg::ARG_NONE;
      status_bits  <= 8'd0;
      resolution   <= 8'd0;
      sample_rate  <= 8'd0;
      wrap_mode    <= 1'b0;
      mouse_kind   <= ps2m_pkg::KIND_STD;
      detect_phase <= ps2m_pkg::DET_IDLE;
      ax           <= '0;
      ay           <= '0;
      aw           <= '0;
      held         <= 5'd0;
    end else begin
      if (push_ok) begin
        wp    <= ptr_inc(wp);
        count <= count + CW'(1);
      end
      if (cmd.rd && count != '0) begin
        rp    <= ptr_inc(rp);
        count <= count - CW'(1);
      end
      if (cmd.acc) begin
        ax <= sat(sum_x);
        ay <= sat(sum_y);
        aw <= sat(sum_w);
      end
      if (cmd.held_set) begin
        held <= btn_q;
      end
      if (cmd.pkt_sub) begin
        ax <= ax - dx_c;
        ay <= ay - dy_c;
        aw <= aw - dz_sub;
      end
      if (cmd.acc_clear) begin
        ax <= '0;
        ay <= '0;
        aw <= '0;
      end
      if (cmd.exec) begin
        pending <= ps2m_pkg::ARG_NONE;
        if (pending == ps2m_pkg::ARG_RATE) begin
          sample_rate <= byte_q;
          case (detect_phase)
            ps2m_pkg::DET_200: begin
              if (byte_q == ps2m_pkg::RATE_100) begin
                detect_phase <= ps2m_pkg::DET_IMPS;
              end else if (byte_q == ps2m_pkg::RATE_200) begin
                detect_phase <= ps2m_pkg::DET_IMEX;
              end else begin
                detect_phase <= ps2m_pkg::DET_IDLE;
              end
            end
            ps2m_pkg::DET_IMPS: begin
              if (byte_q == ps2m_pkg::RATE_80) begin
                mouse_kind <= ps2m_pkg::KIND_IMPS;
              end
              detect_phase <= ps2m_pkg::DET_IDLE;
            end
            ps2m_pkg::DET_IMEX: begin
              if (byte_q == ps2m_pkg::RATE_80) begin
                mouse_kind <= ps2m_pkg::KIND_IMEX;
              end
              detect_phase <= ps2m_pkg::DET_IDLE;
            end
            default: begin
              if (byte_q == ps2m_pkg::RATE_200) begin
                detect_phase <= ps2m_pkg::DET_200;
              end
            end
          endcase
        end else if (pending == ps2m_pkg::ARG_RES) begin
          resolution <= byte_q;
        end else if (wrap_mode && byte_q == ps2m_pkg::CMD_WRAP_OFF) begin
          wrap_mode <= 1'b0;
        end else if (!wrap_mode || byte_q == ps2m_pkg::CMD_RESET) begin
          unique case (byte_q)
            ps2m_pkg::CMD_SCALE11: status_bits[ps2m_pkg::ST_SCALE21_BIT] <= 1'b0;
            ps2m_pkg::CMD_SCALE21: status_bits[ps2m_pkg::ST_SCALE21_BIT] <= 1'b1;
            ps2m_pkg::CMD_STREAM:  status_bits[ps2m_pkg::ST_REMOTE_BIT]  <= 1'b0;
            ps2m_pkg::CMD_REMOTE:  status_bits[ps2m_pkg::ST_REMOTE_BIT]  <= 1'b1;
            ps2m_pkg::CMD_ENABLE:  status_bits[ps2m_pkg::ST_ENABLED_BIT] <= 1'b1;
            ps2m_pkg::CMD_DISABLE: status_bits[ps2m_pkg::ST_ENABLED_BIT] <= 1'b0;
            ps2m_pkg::CMD_WRAP_ON: wrap_mode <= 1'b1;
            ps2m_pkg::CMD_SET_RES: pending <= ps2m_pkg::ARG_RES;
            ps2m_pkg::CMD_SET_RATE: pending <= ps2m_pkg::ARG_RATE;
            ps2m_pkg::CMD_DEFAULTS: begin
              sample_rate <= ps2m_pkg::DEF_RATE;
              resolution  <= ps2m_pkg::DEF_RES;
              status_bits <= 8'd0;
            end
            ps2m_pkg::CMD_RESET: begin
              sample_rate <= ps2m_pkg::DEF_RATE;
              resolution  <= ps2m_pkg::DEF_RES;
              status_bits <= 8'd0;
              mouse_kind  <= ps2m_pkg::KIND_STD;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // reply plan, taken from the state before the command executes
  always_comb begin
    plan_c = ps2m_pkg::PL_NONE;
    if (pending == ps2m_pkg::ARG_RATE || pending == ps2m_pkg::ARG_RES) begin
      plan_c = ps2m_pkg::PL_ACK;
    end else if (wrap_mode && byte_q == ps2m_pkg::CMD_WRAP_OFF) begin
      plan_c = ps2m_pkg::PL_ACK;
    end else if (wrap_mode && byte_q != ps2m_pkg::CMD_RESET) begin
      plan_c = ps2m_pkg::PL_ECHO;
    end else begin
      unique case (byte_q)
        ps2m_pkg::CMD_SCALE11, ps2m_pkg::CMD_SCALE21, ps2m_pkg::CMD_STREAM,
        ps2m_pkg::CMD_REMOTE, ps2m_pkg::CMD_ENABLE, ps2m_pkg::CMD_DISABLE,
        ps2m_pkg::CMD_WRAP_ON, ps2m_pkg::CMD_SET_RES, ps2m_pkg::CMD_SET_RATE,
        ps2m_pkg::CMD_DEFAULTS: plan_c = ps2m_pkg::PL_ACK;
        ps2m_pkg::CMD_GET_ID:   plan_c = ps2m_pkg::PL_ACK_KIND;
        ps2m_pkg::CMD_INFO:     plan_c = ps2m_pkg::PL_INFO;
        ps2m_pkg::CMD_POLL:     plan_c = ps2m_pkg::PL_POLL;
        ps2m_pkg::CMD_RESET:    plan_c = ps2m_pkg::PL_RESET;
        default:                plan_c = ps2m_pkg::PL_NONE;
      endcase
    end
  end

  assign status.plan       = plan_c;
  assign status.enabled    = status_bits[ps2m_pkg::ST_ENABLED_BIT];
  assign status.remote     = status_bits[ps2m_pkg::ST_REMOTE_BIT];
  assign status.room       = (count < CNT_ROOM);
  assign status.full       = (count == CNT_FULL);
  assign status.accum_zero = (ax == '0) && (ay == '0) && (aw == '0);
  assign status.null_event = status.accum_zero && (held == btn_q);
  assign status.kind_ext   = (mouse_kind == ps2m_pkg::KIND_IMPS) ||
                             (mouse_kind == ps2m_pkg::KIND_IMEX);
  assign status.clear_last = (clear_addr == PTR_LAST);

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("fifo count above depth");
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    cmd.push && !cmd.dev_reset && count == CNT_FULL |=> $stable(count))
    else $error("push into full fifo changed count");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.rd && !cmd.dev_reset && count != '0 |=> count == $past(count) - CW'(1))
    else $error("read did not pop one byte");

endmodule

// ===== rtl/ps2m_ctrl.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse engine controller
// Sequences command replies, motion packets, reads and result transfers.
// ----------------------------------------------------------------------------
module ps2m_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [1:0]           operation,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ps2m_pkg::dp_cmd_t    cmd,
  input  ps2m_pkg::dp_status_t status
);

  ps2m_pkg::state_t state, state_next;
  ps2m_pkg::plan_t  plan, plan_next;
  logic [1:0]       k, k_next;
  logic             poll, poll_next;
  logic             result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ps2m_pkg::S_CLEAR;
      plan         <= ps2m_pkg::PL_NONE;
      k            <= 2'd0;
      poll         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      plan         <= plan_next;
      k            <= k_next;
      poll         <= poll_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    plan_next  = plan;
    k_next     = k;
    poll_next  = poll;
    item_ready = 1'b0;
    cmd        = '0;
    cmd.bsel   = ps2m_pkg::BS_ACK;
    unique case (state)
      ps2m_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          unique case (ps2m_pkg::op_t'(operation))
            ps2m_pkg::OP_CMD:    state_next = ps2m_pkg::S_CMD;
            ps2m_pkg::OP_MOTION: state_next = ps2m_pkg::S_MOT_ACC;
            ps2m_pkg::OP_READ:   state_next = ps2m_pkg::S_RD;
            default:             state_next = ps2m_pkg::S_RST;
          endcase
        end
      end
      ps2m_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = ps2m_pkg::S_IDLE;
        end
      end
      ps2m_pkg::S_CMD: begin
        cmd.exec  = 1'b1;
        plan_next = status.plan;
        k_next    = 2'd0;
        state_next = (status.plan == ps2m_pkg::PL_NONE) ? ps2m_pkg::S_DONE : ps2m_pkg::S_PUSH;
      end
      ps2m_pkg::S_PUSH: begin
        cmd.push = 1'b1;
        cmd.bsel = ps2m_pkg::plan_byte(plan, k);
        if (ps2m_pkg::plan_last(plan, k)) begin
          k_next    = 2'd0;
          poll_next = 1'b1;
          state_next = (plan == ps2m_pkg::PL_POLL) ? ps2m_pkg::S_PKT : ps2m_pkg::S_DONE;
        end else begin
          k_next = k + 2'd1;
        end
      end
      ps2m_pkg::S_MOT_ACC: begin
        if (status.enabled) begin
          cmd.acc    = 1'b1;
          state_next = ps2m_pkg::S_MOT_CHK;
        end else begin
          state_next = ps2m_pkg::S_DONE;
        end
      end
      ps2m_pkg::S_MOT_CHK: begin
        if (status.null_event) begin
          state_next = ps2m_pkg::S_DONE;
        end else begin
          cmd.held_set = 1'b1;
          k_next       = 2'd0;
          poll_next    = 1'b0;
          state_next = (!status.remote && status.room) ? ps2m_pkg::S_PKT : ps2m_pkg::S_DONE;
        end
      end
      ps2m_pkg::S_PKT: begin
        cmd.push = 1'b1;
        cmd.bsel = ps2m_pkg::pkt_byte(k);
        if (k == 2'd3 || (k == 2'd2 && !status.kind_ext)) begin
          state_next = ps2m_pkg::S_PKT_SUB;
        end else begin
          k_next = k + 2'd1;
        end
      end
      ps2m_pkg::S_PKT_SUB: begin
        cmd.pkt_sub = 1'b1;
        state_next  = ps2m_pkg::S_PKT_CHK;
      end
      ps2m_pkg::S_PKT_CHK: begin
        k_next = 2'd0;
        if (poll || status.accum_zero) begin
          state_next = ps2m_pkg::S_DONE;
        end else if (status.full) begin
          // remaining packets would all be dropped: drain the deltas
          cmd.acc_clear = 1'b1;
          state_next    = ps2m_pkg::S_DONE;
        end else begin
          state_next = ps2m_pkg::S_PKT;
        end
      end
      ps2m_pkg::S_RD: begin
        cmd.rd     = 1'b1;
        state_next = ps2m_pkg::S_RD_WAIT;
      end
      ps2m_pkg::S_RD_WAIT: begin
        cmd.capture = 1'b1;
        state_next  = ps2m_pkg::S_DONE;
      end
      ps2m_pkg::S_RST: begin
        cmd.dev_reset = 1'b1;
        state_next    = ps2m_pkg::S_DONE;
      end
      ps2m_pkg::S_DONE: begin
        // hold until the output register is free
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ps2m_pkg::S_IDLE;
        end
      end
      default: state_next = ps2m_pkg::S_IDLE;
    endcase
  end

  assign result_valid_next = cmd.out_load ? 1'b1 : (result_ready ? 1'b0 : result_valid);

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> state == ps2m_pkg::S_DONE)
    else $error("result loaded outside done state");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !result_valid || result_ready)
    else $error("pending result overwritten");
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !item_ready)
    else $error("item taken during clearing pass");

endmodule

// ===== tb/sv/ps2_mouse_device_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse device engine testbench
// Drives host commands, motion events, data reads and resets into the engine
// and checks every result against a cycle-free model of the mouse.
// ----------------------------------------------------------------------------
module ps2_mouse_device_engine_top_tb;

  localparam int DEPTH    = ps2m_pkg::FIFO_DEPTH_DEF;
  localparam int HEADROOM = ps2m_pkg::EVENT_HEADROOM_DEF;
  localparam int MAX_CYC  = 2000000;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       irq_level;
    logic [8:0] fifo_level;
  } mouse_result_t;

  // Mouse model and the queue of results it predicts
  class mouse_scoreboard;
    logic [7:0]  mem[DEPTH];
    int          rd_ptr, wr_ptr, count;
    ps2m_pkg::arg_t pending;
    logic [7:0]  status, res, rate;
    logic        wrap;
    logic [2:0]  kind;
    ps2m_pkg::det_t det;
    int          ax, ay, az;
    logic [4:0]  buttons;
    mouse_result_t waiting[$];
    int          errors, checked;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      clear_state();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_state();
      rd_ptr = 0; wr_ptr = 0; count = 0; pending = ps2m_pkg::ARG_NONE;
      status = 0; res = 0; rate = 0; wrap = 0; kind = ps2m_pkg::KIND_STD;
      det = ps2m_pkg::DET_IDLE;
      ax = 0; ay = 0; az = 0; buttons = 0;
    endfunction

    function void push(logic [7:0] b);
      if (count >= DEPTH) return;
      mem[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      count++;
    endfunction

    function int sat16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int clamp(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void packet();
      int dx, dy, dz;
      logic [7:0] head;
      dx = clamp(ax, 127);
      dy = clamp(ay, 127);
      dz = az;
      head = 8'h08 | (dx < 0 ? 8'h10 : 8'h00) | (dy < 0 ? 8'h20 : 8'h00)
             | {5'd0, buttons[2:0]};
      push(head);
      push(dx[7:0]);
      push(dy[7:0]);
      if (kind == ps2m_pkg::KIND_IMPS) begin
        dz = clamp(dz, 127);
        push(dz[7:0]);
      end else if (kind == ps2m_pkg::KIND_IMEX) begin
        dz = clamp(dz, 7);
        push({2'b00, buttons[4:3], dz[3:0]});
      end
      ax -= dx; ay -= dy; az -= dz;
    endfunction

    function void motion(logic signed [10:0] x, logic signed [10:0] y,
                         logic signed [10:0] z, logic [4:0] btn);
      if (!status[ps2m_pkg::ST_ENABLED_BIT]) return;
      ax = sat16(ax + int'(x));
      ay = sat16(ay - int'(y));
      az = sat16(az + int'(z));
      if (ax == 0 && ay == 0 && az == 0 && buttons == btn) return;
      buttons = btn;
      if (!status[ps2m_pkg::ST_REMOTE_BIT] && count < DEPTH - HEADROOM) begin
        forever begin
          packet();
          if (ax == 0 && ay == 0 && az == 0) break;
          if (count >= DEPTH) begin
            ax = 0; ay = 0; az = 0;
            break;
          end
        end
      end
    endfunction

    function void rate_arg(logic [7:0] v);
      rate = v;
      case (det)
        ps2m_pkg::DET_200:
          det = (v == ps2m_pkg::RATE_100) ? ps2m_pkg::DET_IMPS :
                (v == ps2m_pkg::RATE_200) ? ps2m_pkg::DET_IMEX : ps2m_pkg::DET_IDLE;
        ps2m_pkg::DET_IMPS: begin
          if (v == ps2m_pkg::RATE_80) kind = ps2m_pkg::KIND_IMPS;
          det = ps2m_pkg::DET_IDLE;
        end
        ps2m_pkg::DET_IMEX: begin
          if (v == ps2m_pkg::RATE_80) kind = ps2m_pkg::KIND_IMEX;
          det = ps2m_pkg::DET_IDLE;
        end
        default:  if (v == ps2m_pkg::RATE_200) det = ps2m_pkg::DET_200;
      endcase
      push(ps2m_pkg::REPLY_ACK);
    endfunction

    function void command(logic [7:0] v);
      if (pending == ps2m_pkg::ARG_RATE) begin
        rate_arg(v);
        pending = ps2m_pkg::ARG_NONE;
        return;
      end
      if (pending == ps2m_pkg::ARG_RES) begin
        res = v;
        push(ps2m_pkg::REPLY_ACK);
        pending = ps2m_pkg::ARG_NONE;
        return;
      end
      pending = ps2m_pkg::ARG_NONE;
      if (wrap) begin
        if (v == ps2m_pkg::CMD_WRAP_OFF) begin
          wrap = 0;
          push(ps2m_pkg::REPLY_ACK);
          return;
        end
        if (v != ps2m_pkg::CMD_RESET) begin
          push(v);
          return;
        end
      end
      case (v)
        ps2m_pkg::CMD_SCALE11: begin
          status[ps2m_pkg::ST_SCALE21_BIT] = 0; push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_SCALE21: begin
          status[ps2m_pkg::ST_SCALE21_BIT] = 1; push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_STREAM: begin
          status[ps2m_pkg::ST_REMOTE_BIT] = 0; push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_WRAP_ON: begin wrap = 1; push(ps2m_pkg::REPLY_ACK); end
        ps2m_pkg::CMD_REMOTE: begin
          status[ps2m_pkg::ST_REMOTE_BIT] = 1; push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_GET_ID: begin push(ps2m_pkg::REPLY_ACK); push({5'd0, kind}); end
        ps2m_pkg::CMD_SET_RES: begin
          pending = ps2m_pkg::ARG_RES; push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_SET_RATE: begin
          pending = ps2m_pkg::ARG_RATE; push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_INFO: begin
          push(ps2m_pkg::REPLY_ACK); push(status); push(res); push(rate);
        end
        ps2m_pkg::CMD_POLL: begin push(ps2m_pkg::REPLY_ACK); packet(); end
        ps2m_pkg::CMD_ENABLE: begin
          status[ps2m_pkg::ST_ENABLED_BIT] = 1; push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_DISABLE: begin
          status[ps2m_pkg::ST_ENABLED_BIT] = 0; push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_DEFAULTS: begin
          rate = ps2m_pkg::DEF_RATE; res = ps2m_pkg::DEF_RES; status = 0;
          push(ps2m_pkg::REPLY_ACK);
        end
        ps2m_pkg::CMD_RESET: begin
          rate = ps2m_pkg::DEF_RATE; res = ps2m_pkg::DEF_RES; status = 0;
          kind = ps2m_pkg::KIND_STD;
          push(ps2m_pkg::REPLY_ACK); push(ps2m_pkg::REPLY_BAT); push({5'd0, kind});
        end
        default: ;
      endcase
    endfunction

    // Note one accepted input item and queue its result
    function void note_item(ps2m_pkg::op_t op, logic [7:0] cb, logic signed [10:0] x,
                            logic signed [10:0] y, logic signed [10:0] z, logic [4:0] btn);
      mouse_result_t r;
      r.read_byte = 8'h00;
      case (op)
        ps2m_pkg::OP_CMD:    command(cb);
        ps2m_pkg::OP_MOTION: motion(x, y, z, btn);
        ps2m_pkg::OP_READ: begin
          if (count == 0) begin
            r.read_byte = mem[(rd_ptr + DEPTH - 1) % DEPTH];
          end else begin
            r.read_byte = mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            count--;
          end
        end
        default:   clear_state();
      endcase
      r.irq_level = (count != 0);
      r.fifo_level = count[8:0];
      waiting.push_back(r);
    endfunction

    function void check_result(mouse_result_t got);
      mouse_result_t exp_r;
      checked++;
      if (waiting.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = waiting.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: byte exp %h got %h, irq exp %b got %b, level exp %0d got %0d",
                   exp_r.read_byte, got.read_byte, exp_r.irq_level, got.irq_level,
                   exp_r.fifo_level, got.fifo_level);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ps2m_item_if   item();
  ps2m_result_if result();

  ps2_mouse_device_engine_top u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  mouse_scoreboard sb;
  int  cycles;
  bit  quiet;
  bit  stall_long;
  int  n_cmd, n_motion, n_read, n_reset;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    item.valid = 0;
    item.operation = ps2m_pkg::OP_CMD;
    item.command_byte = 0;
    item.delta_x = 0;
    item.delta_y = 0;
    item.delta_wheel = 0;
    item.button_bits = 0;
    result.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check results and note inputs at each transfer
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      sb.check_result({result.read_byte, result.irq_level, result.fifo_level});
    if (!rst && item.valid && item.ready)
      sb.note_item(ps2m_pkg::op_t'(item.operation), item.command_byte, item.delta_x,
                   item.delta_y, item.delta_wheel, item.button_bits);
  end

  // Receiver: random stall bursts, a long hold-off on request
  initial begin
    int k;
    @(negedge rst);
    forever begin
      if (stall_long) begin
        result.ready <= 0;
        for (k = 0; k < 400; k++) @(posedge clk);
        stall_long = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result.ready <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        result.ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(ps2m_pkg::op_t op, logic [7:0] cb, logic signed [10:0] x,
                           logic signed [10:0] y, logic signed [10:0] z, logic [4:0] btn);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item.valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item.valid <= 1;
    item.operation <= op;
    item.command_byte <= cb;
    item.delta_x <= x;
    item.delta_y <= y;
    item.delta_wheel <= z;
    item.button_bits <= btn;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    case (op)
      ps2m_pkg::OP_CMD:    n_cmd++;
      ps2m_pkg::OP_MOTION: n_motion++;
      ps2m_pkg::OP_READ:   n_read++;
      default:             n_reset++;
    endcase
  endtask

  task automatic cmd(logic [7:0] b);
    send_item(ps2m_pkg::OP_CMD, b, 11'sd0, 11'sd0, 11'sd0, 5'd0);
  endtask

  task automatic move(int x, int y, int z, logic [4:0] btn);
    send_item(ps2m_pkg::OP_MOTION, 8'($urandom), x[10:0], y[10:0], z[10:0], btn);
  endtask

  task automatic reads(int n);
    repeat (n) send_item(ps2m_pkg::OP_READ, 8'($urandom), 11'($urandom), 11'($urandom),
                         11'($urandom), 5'($urandom));
  endtask

  task automatic set_rate(logic [7:0] r);
    cmd(ps2m_pkg::CMD_SET_RATE);
    cmd(r);
  endtask

  task automatic random_item();
    int sel;
    logic [7:0] cmds[17] = '{ps2m_pkg::CMD_SCALE11, ps2m_pkg::CMD_SCALE21,
                             ps2m_pkg::CMD_SET_RES, ps2m_pkg::CMD_INFO,
                             ps2m_pkg::CMD_STREAM, ps2m_pkg::CMD_POLL,
                             ps2m_pkg::CMD_WRAP_OFF, ps2m_pkg::CMD_WRAP_ON,
                             ps2m_pkg::CMD_REMOTE, ps2m_pkg::CMD_GET_ID,
                             ps2m_pkg::CMD_SET_RATE, ps2m_pkg::CMD_ENABLE,
                             ps2m_pkg::CMD_ENABLE, ps2m_pkg::CMD_DISABLE,
                             ps2m_pkg::CMD_DEFAULTS, ps2m_pkg::CMD_RESET,
                             ps2m_pkg::CMD_STREAM};
    sel = $urandom_range(0, 99);
    if (sel < 30) reads($urandom_range(1, 6));
    else if (sel < 55) begin
      if ($urandom_range(0, 3) == 0)
        move(int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
             int'($urandom_range(0, 2047)) - 1024, 5'($urandom));
      else
        move(int'($urandom_range(0, 60)) - 30, int'($urandom_range(0, 60)) - 30,
             int'($urandom_range(0, 6)) - 3, 5'($urandom));
    end else if (sel < 80) cmd(cmds[$urandom_range(0, 16)]);
    else if (sel < 86) begin
      set_rate(ps2m_pkg::RATE_200);
      set_rate($urandom_range(0, 1) ? ps2m_pkg::RATE_100 : ps2m_pkg::RATE_200);
      set_rate($urandom_range(0, 3) ? ps2m_pkg::RATE_80 : 8'($urandom));
    end else if (sel < 93) cmd(8'($urandom));
    else if (sel < 95) send_item(ps2m_pkg::OP_RESET, 8'($urandom), 11'sd0, 11'sd0, 11'sd0,
                                 5'd0);
    else begin
      cmd(ps2m_pkg::CMD_ENABLE);
      cmd(ps2m_pkg::CMD_STREAM);
    end
  endtask

  initial begin
    int i, wait_cyc;
    sb = new();
    cycles = 0;
    quiet = 0;
    stall_long = 0;
    n_cmd = 0; n_motion = 0; n_read = 0; n_reset = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty read, IMPS and IMEX detect, extremes, wrap mode, overflow
    reads(1);
    cmd(ps2m_pkg::CMD_GET_ID);
    move(5, 5, 0, 5'h00);
    cmd(ps2m_pkg::CMD_ENABLE);
    move(1023, -1024, 1023, 5'h1f);
    move(0, 0, 0, 5'h1f);
    set_rate(ps2m_pkg::RATE_200); set_rate(ps2m_pkg::RATE_100); set_rate(ps2m_pkg::RATE_80);
    move(-1024, 1023, -1024, 5'h00);
    set_rate(ps2m_pkg::RATE_200); set_rate(ps2m_pkg::RATE_200); set_rate(ps2m_pkg::RATE_80);
    move(300, 20, 9, 5'h1a);
    cmd(ps2m_pkg::CMD_SET_RES); cmd(8'h03);
    cmd(ps2m_pkg::CMD_SCALE21); cmd(ps2m_pkg::CMD_INFO);
    cmd(ps2m_pkg::CMD_WRAP_ON); cmd(8'h55); cmd(ps2m_pkg::CMD_RESET);
    cmd(ps2m_pkg::CMD_WRAP_OFF);
    cmd(8'h00); cmd(ps2m_pkg::CMD_WRAP_OFF);
    cmd(ps2m_pkg::CMD_REMOTE);
    move(1023, 1023, 1023, 5'h03);
    cmd(ps2m_pkg::CMD_POLL); cmd(ps2m_pkg::CMD_STREAM);
    cmd(ps2m_pkg::CMD_DEFAULTS);
    reads(40);

    // Fill the FIFO while the receiver holds off
    cmd(ps2m_pkg::CMD_ENABLE);
    stall_long = 1;
    for (i = 0; i < 20; i++) cmd(ps2m_pkg::CMD_INFO);
    for (i = 0; i < 40; i++) move(1023, -1024, 3, i[4:0]);
    reads(100);

    for (i = 0; i < 200; i++) begin
      if (i == 150) quiet = 1;
      random_item();
    end
    item.valid <= 0;

    wait_cyc = 0;
    while (sb.waiting.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (50) @(posedge clk);
    $display("covered %0d commands, %0d motion events, %0d reads, %0d resets; %0d results",
             n_cmd, n_motion, n_read, n_reset, sb.checked);
    if (sb.errors == 0 && sb.waiting.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("errors %0d, results still owed %0d", sb.errors, sb.waiting.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
